>>> design/fez_pkg.sv
`timescale 1ns / 1ps

package fez_pkg;

    // Longest frame; a frame is closed here if no last flag has come.
    localparam int FRAME_SAMPLES = 256;

    localparam int SAMPLE_W  = 16;
    localparam int DEV_W     = SAMPLE_W + 1;
    localparam int ENERGY_W  = 32;
    localparam int ZC_W      = 8;

    // Sample count must hold FRAME_SAMPLES itself.
    localparam int COUNT_W   = $clog2(FRAME_SAMPLES + 1);
    // Frame energy sum: FRAME_SAMPLES squares of up to 32 bits.
    localparam int SUM_W     = ENERGY_W + $clog2(FRAME_SAMPLES);
    // Sign change sum: at most 2 per sample pair.
    localparam int SC_W      = $clog2(2 * FRAME_SAMPLES);
    // Divider step counter, one quotient bit per cycle.
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc_dev;
        logic calc_sq;
        logic accum;
        logic div_step;
        logic out_load;
    } fez_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
    } fez_status_t;

endpackage

>>> design/fez_ctrl.sv
`timescale 1ns / 1ps

module fez_ctrl
    import fez_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  fez_status_t status,
    output fez_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEV  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Sequencer: one sample per pass, then a divide at frame end.
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DEV;
                end
            end
            ST_DEV: begin
                cmd.calc_dev = 1'b1;
                state_next   = ST_SQ;
            end
            ST_SQ: begin
                cmd.calc_sq = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.accum = 1'b1;
                if (status.frame_end) begin
                    div_cnt_next = DIV_CNT_W'(SUM_W - 1);
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set on load, cleared when the request is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/fez_datapath.sv
`timescale 1ns / 1ps

module fez_datapath
    import fez_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [SAMPLE_W-1:0]    cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  fez_cmd_t               cmd,
    output fez_status_t            status
);

    logic signed [SAMPLE_W-1:0] dc_offset_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [SAMPLE_W-1:0]        mag_reg;
    logic [1:0]                 sign_reg;
    logic [ENERGY_W-1:0]        sq_reg;

    logic [SUM_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [1:0]          prev_sign_reg;
    logic [SC_W-1:0]     sc_reg;
    logic [ENERGY_W-1:0] peak_reg;

    logic [SUM_W-1:0]    quot_reg;
    logic [COUNT_W-1:0]  divisor_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [ZC_W-1:0]     zc_frame_reg;
    logic [ENERGY_W-1:0] peak_frame_reg;

    logic [ENERGY_W-1:0] mean_out_reg;
    logic [ZC_W-1:0]     zc_out_reg;
    logic [ENERGY_W-1:0] peak_out_reg;

    logic signed [DEV_W-1:0] dev;
    logic [DEV_W-1:0]        dev_neg;
    logic [SUM_W-1:0]        sum_plus;
    logic [COUNT_W-1:0]      count_plus;
    logic signed [2:0]       sign_diff;
    logic [1:0]              sign_abs;
    logic [SC_W-1:0]         sc_plus;
    logic [SC_W-2:0]         sc_half;
    logic [ENERGY_W-1:0]     peak_plus;
    logic [ZC_W-1:0]         zc_sat;
    logic [COUNT_W:0]        rem_shift;
    logic [COUNT_W:0]        rem_diff;
    logic                    quot_bit;

    // Deviation from the zero level and its magnitude.
    assign dev     = DEV_W'(sample_reg) - DEV_W'(dc_offset_reg);
    assign dev_neg = -dev;

    // Per-sample accumulation terms.
    assign sum_plus   = sum_reg + SUM_W'(sq_reg);
    assign count_plus = count_reg + 1'b1;
    assign sign_diff  = {sign_reg[1], sign_reg} - {prev_sign_reg[1], prev_sign_reg};
    assign sign_abs   = sign_diff[2] ? 2'((-sign_diff)) : sign_diff[1:0];
    assign sc_plus    = (count_reg != '0) ? sc_reg + SC_W'(sign_abs) : sc_reg;
    assign sc_half    = sc_plus[SC_W-1:1];
    assign zc_sat     = (sc_half > (SC_W-1)'(255)) ? 8'hFF : ZC_W'(sc_half);
    assign peak_plus  = (sq_reg > peak_reg) ? sq_reg : peak_reg;

    assign status.frame_end = last_reg ||
                              (count_plus >= COUNT_W'(FRAME_SAMPLES));

    // Restoring divide step: one quotient bit per cycle, MSB first.
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign quot_bit  = (rem_shift >= {1'b0, divisor_reg});

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_offset_reg <= '0;
        end else if (cfg_wen) begin
            dc_offset_reg <= cfg_wdata;
        end
    end

    // Input capture, deviation and square stages.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            last_reg   <= s_tlast;
        end
        if (cmd.calc_dev) begin
            mag_reg  <= dev[DEV_W-1] ? dev_neg[SAMPLE_W-1:0] : dev[SAMPLE_W-1:0];
            sign_reg <= dev[DEV_W-1] ? 2'b11 : ((dev != '0) ? 2'b01 : 2'b00);
        end
        if (cmd.calc_sq) begin
            sq_reg <= ENERGY_W'(mag_reg) * ENERGY_W'(mag_reg);
        end
    end

    // Frame accumulators and running peak.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            prev_sign_reg <= '0;
            sc_reg        <= '0;
            peak_reg      <= '0;
        end else if (cmd.accum) begin
            peak_reg <= peak_plus;
            if (status.frame_end) begin
                sum_reg       <= '0;
                count_reg     <= '0;
                prev_sign_reg <= '0;
                sc_reg        <= '0;
            end else begin
                sum_reg       <= sum_plus;
                count_reg     <= count_plus;
                prev_sign_reg <= sign_reg;
                sc_reg        <= sc_plus;
            end
        end
    end

    // Divider operands are loaded at frame end and stepped afterward.
    always_ff @(posedge aclk) begin
        if (cmd.accum && status.frame_end) begin
            quot_reg       <= sum_plus;
            divisor_reg    <= count_plus;
            rem_reg        <= '0;
            zc_frame_reg   <= zc_sat;
            peak_frame_reg <= peak_plus;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[SUM_W-2:0], quot_bit};
            rem_reg  <= quot_bit ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mean_out_reg <= quot_reg[ENERGY_W-1:0];
            zc_out_reg   <= zc_frame_reg;
            peak_out_reg <= peak_frame_reg;
        end
    end

    assign m_tdata = {peak_out_reg, zc_out_reg, mean_out_reg};

endmodule

>>> design/frame_energy_zero_cross_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                           Payload
// s_        in         s_tvalid s_tready s_tdata s_tlast  sample, last_in_frame
// m_        out        m_tvalid m_tready m_tdata          mean, crossings, peak
// cfg_      in         cfg_wen cfg_wdata                  dc_offset
//
// Each sample goes through capture, deviation, square and accumulate in turn.
// A sample that ends a frame adds a 1-bit-per-cycle restoring divide of
// SUM_W quotient bits (40 at 256 samples), then a load of the output register.
// Reset is synchronous and active low; it clears the offset, peak and frame state.
// A result waiting on m_tready holds only the next frame's final load; samples
// of the next frame are taken meanwhile.

module frame_energy_zero_cross_core
    import fez_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [SAMPLE_W-1:0]    cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [15:0] sample
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata     // [31:0] mean_energy,
                                               // [39:32] zero_crossings,
                                               // [71:40] peak_energy
);

    fez_cmd_t    cmd;
    fez_status_t status;

    fez_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fez_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    // The output register is never overwritten while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register loaded over a pending result");

    // A loaded result is presented in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    // Only one sample is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample accepted during processing");

    // No sample is taken while the divider runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.div_step && s_tready))
        else $error("input ready during division");

endmodule
